FILE: rtl/core/hrf_pkg.sv
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared types and constants for the HTTP request framer.
// ----------------------------------------------------------------------------
package hrf_pkg;

   localparam int MAX_LEN_WIDTH  = 31;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // register word index (paddr[2])
   localparam logic REG_MAX_BODY_LENGTH = 1'b0;

   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_C = 8'h43;

   // "Content-Length:" is 15 characters, positions 0..14
   localparam logic [3:0] NAME_LAST = 4'd14;
   localparam logic [3:0] NAME_LEN  = 4'd15;

   localparam logic [MAX_LEN_WIDTH-1:0] MAX_LEN_RESET = {MAX_LEN_WIDTH{1'b1}};

   typedef struct packed {
      logic [7:0] out_byte;
      logic       in_body;
      logic       last;
      logic       length_error;
   } hrf_beat_type;

   typedef struct packed {
      logic out_valid;
      logic skid_full;
   } hrf_buf_status_type;

   function automatic logic [7:0] name_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0:    c = 8'h43; // C
         4'd1:    c = 8'h6F; // o
         4'd2:    c = 8'h6E; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6E; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2D; // -
         4'd8:    c = 8'h4C; // L
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6E; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         4'd14:   c = 8'h3A; // :
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/core/http_request_framer_core.sv
// ----------------------------------------------------------------------------
// http_request_framer_core
// Tags HTTP request boundaries in a received byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per clock while req_stall is low and returns it through the output
// buffer, tagged as a header or body byte, with last on the final byte of each
// request and length_error on that byte when the Content-Length value was
// malformed, negative or above max_body_length. All per-byte parsing is
// combinational logic in front of a two-entry output buffer; the parse state loop
// (length value times ten plus digit, compared against the limit) sets the clock.
// req_stall rises only when both buffer entries are full, so a stalled output still
// lets one more byte in. max_body_length sits at byte address 0; the user must write
// it only while the block is idle, and the block itself does not enforce this.
module http_request_framer_core #(
   parameter int LENGTH_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_in_body,
   output logic                                rsp_last,
   output logic                                rsp_length_error,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hrf_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [hrf_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [hrf_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import hrf_pkg::*;

   logic [MAX_LEN_WIDTH-1:0] max_len_ff;
   logic                     accept;
   logic                     csr_write;
   hrf_beat_type             beat;
   hrf_beat_type             beat_out;
   hrf_buf_status_type       buf_status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_write && csr_paddr[2] == REG_MAX_BODY_LENGTH) begin
         max_len_ff <= csr_pwdata[MAX_LEN_WIDTH-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_MAX_BODY_LENGTH)
                       ? {{(CSR_DATA_WIDTH-MAX_LEN_WIDTH){1'b0}}, max_len_ff}
                       : '0;

   assign req_stall = buf_status.skid_full;
   assign accept    = req_valid && !req_stall;

   hrf_parser #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_data_byte),
      .max_body_length (max_len_ff),
      .beat            (beat)
   );

   hrf_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .beat_in   (beat),
      .rsp_stall (rsp_stall),
      .beat_out  (beat_out),
      .status    (buf_status)
   );

   assign rsp_valid        = buf_status.out_valid;
   assign rsp_out_byte     = beat_out.out_byte;
   assign rsp_in_body      = beat_out.in_body;
   assign rsp_last         = beat_out.last;
   assign rsp_length_error = beat_out.length_error;

`ifndef SYNTHESIS
   // error is only ever reported on the closing beat of a request
   a_error_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_length_error || rsp_last))
      else $error("length_error without last");

   // skid entry is never occupied while the output register is empty
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid full with empty output register");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("buffer not empty after reset");
`endif

endmodule

FILE: rtl/core/hrf_parser.sv
// ----------------------------------------------------------------------------
// hrf_parser
// Per-byte header scanner: terminator match, length name match, length value
// parse and body countdown. Tags the accepted byte in the same cycle.
// ----------------------------------------------------------------------------
module hrf_parser #(
   parameter int LENGTH_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [7:0]                          data_byte,
   input  logic [hrf_pkg::MAX_LEN_WIDTH-1:0]   max_body_length,
   output hrf_pkg::hrf_beat_type               beat
);
   import hrf_pkg::*;

   localparam int CmpWidth = (LENGTH_WIDTH > MAX_LEN_WIDTH) ? LENGTH_WIDTH : MAX_LEN_WIDTH;

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_SPACES,
      PH_SIGN_POS,
      PH_SIGN_NEG,
      PH_DIG_POS,
      PH_DIG_NEG,
      PH_DONE,
      PH_BODY
   } phase_type;

   phase_type               phase_ff,  phase_in;
   logic [1:0]              term_ff,   term_in;
   logic [3:0]              name_ff,   name_in;
   logic                    found_ff,  found_in;
   logic                    error_ff,  error_in;
   logic [LENGTH_WIDTH-1:0] value_ff,  value_in;
   logic [LENGTH_WIDTH-1:0] remain_ff, remain_in;

   logic                    is_digit;
   logic [3:0]              digit;
   logic [LENGTH_WIDTH+3:0] prod;
   logic                    overflow;
   logic [LENGTH_WIDTH-1:0] value_acc;
   logic [LENGTH_WIDTH-1:0] value_first;
   logic [LENGTH_WIDTH-1:0] remain_dec;
   logic                    term_match;
   logic                    term_done;
   logic                    too_big;
   logic                    body_beat;
   logic                    last_beat;

   assign is_digit    = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign digit       = data_byte[3:0];
   // value * 10 + digit as (v << 3) + (v << 1) + d
   assign prod        = ({4'b0, value_ff} << 3) + ({4'b0, value_ff} << 1)
                        + {{LENGTH_WIDTH{1'b0}}, digit};
   assign overflow    = |prod[LENGTH_WIDTH+3:LENGTH_WIDTH];
   assign value_acc   = overflow ? {LENGTH_WIDTH{1'b1}} : prod[LENGTH_WIDTH-1:0];
   assign value_first = {{(LENGTH_WIDTH-4){1'b0}}, digit};
   assign remain_dec  = (remain_ff != '0) ? remain_ff - 1'b1 : remain_ff;
   assign term_match  = term_ff[0] ? (data_byte == CHAR_LF) : (data_byte == CHAR_CR);

   always_comb begin
      phase_in  = phase_ff;
      term_in   = term_ff;
      name_in   = name_ff;
      found_in  = found_ff;
      error_in  = error_ff;
      value_in  = value_ff;
      remain_in = remain_ff;
      term_done = 1'b0;
      too_big   = 1'b0;
      body_beat = 1'b0;
      last_beat = 1'b0;

      if (phase_ff == PH_BODY) begin
         body_beat = 1'b1;
         remain_in = remain_dec;
         last_beat = (remain_dec == '0);
      end else begin
         unique case (phase_ff)
            PH_SEARCH: begin
               if (name_ff != NAME_LEN && data_byte == name_char(name_ff)) begin
                  if (name_ff == NAME_LAST) begin
                     found_in = 1'b1;
                     name_in  = '0;
                     phase_in = PH_SPACES;
                  end else begin
                     name_in = name_ff + 1'b1;
                  end
               end else begin
                  name_in = (data_byte == CHAR_UPPER_C) ? 4'd1 : 4'd0;
               end
            end
            PH_SPACES: begin
               priority if (data_byte == CHAR_SPACE) begin
               end else if (data_byte == CHAR_PLUS) begin
                  phase_in = PH_SIGN_POS;
               end else if (data_byte == CHAR_MINUS) begin
                  phase_in = PH_SIGN_NEG;
               end else if (is_digit) begin
                  value_in = value_first;
                  phase_in = PH_DIG_POS;
               end else begin
                  error_in = 1'b1;
                  phase_in = PH_DONE;
               end
            end
            PH_SIGN_POS, PH_SIGN_NEG: begin
               if (is_digit) begin
                  value_in = value_first;
                  if (phase_ff == PH_SIGN_NEG) begin
                     error_in = error_ff | (digit != 4'd0);
                     phase_in = PH_DIG_NEG;
                  end else begin
                     phase_in = PH_DIG_POS;
                  end
               end else begin
                  error_in = 1'b1;
                  phase_in = PH_DONE;
               end
            end
            PH_DIG_POS, PH_DIG_NEG: begin
               if (is_digit) begin
                  value_in = value_acc;
                  error_in = error_ff | overflow
                             | ((phase_ff == PH_DIG_NEG) && (digit != 4'd0));
               end else begin
                  phase_in = PH_DONE;
               end
            end
            PH_DONE, PH_BODY: begin
            end
         endcase

         if (term_match) begin
            if (term_ff == 2'd3) begin
               term_in   = 2'd0;
               term_done = 1'b1;
            end else begin
               term_in = term_ff + 2'd1;
            end
         end else begin
            term_in = (data_byte == CHAR_CR) ? 2'd1 : 2'd0;
         end

         if (term_done) begin
            too_big = found_in && (error_in ||
                      (CmpWidth'(value_in) > CmpWidth'(max_body_length)));
            if (!found_in || too_big || value_in == '0) begin
               last_beat = 1'b1;
            end else begin
               term_in   = 2'd0;
               name_in   = '0;
               remain_in = value_in;
               phase_in  = PH_BODY;
            end
         end
      end

      // every completed request restarts from a clean header state
      if (last_beat) begin
         phase_in  = PH_SEARCH;
         term_in   = '0;
         name_in   = '0;
         found_in  = 1'b0;
         error_in  = 1'b0;
         value_in  = '0;
         remain_in = '0;
      end
   end

   assign beat.out_byte     = data_byte;
   assign beat.in_body      = body_beat;
   assign beat.last         = last_beat;
   assign beat.length_error = too_big;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEARCH;
         term_ff   <= '0;
         name_ff   <= '0;
         found_ff  <= 1'b0;
         error_ff  <= 1'b0;
         value_ff  <= '0;
         remain_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         term_ff   <= term_in;
         name_ff   <= name_in;
         found_ff  <= found_in;
         error_ff  <= error_in;
         value_ff  <= value_in;
         remain_ff <= remain_in;
      end
   end

endmodule

FILE: rtl/core/hrf_out_buffer.sv
// ----------------------------------------------------------------------------
// hrf_out_buffer
// Two-entry output buffer: result register plus skid register, so the input
// side can still take one more beat after the output stalls.
// ----------------------------------------------------------------------------
module hrf_out_buffer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  hrf_pkg::hrf_beat_type         beat_in,
   input  logic                          rsp_stall,
   output hrf_pkg::hrf_beat_type         beat_out,
   output hrf_pkg::hrf_buf_status_type   status
);
   import hrf_pkg::*;

   logic         out_valid_ff;
   logic         skid_valid_ff;
   hrf_beat_type out_ff;
   hrf_beat_type skid_ff;
   logic         out_free;

   // output register empties or moves on this cycle
   assign out_free = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= accept;
            end
         end else if (accept) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : beat_in;
      end
      if (accept && !out_free) begin
         skid_ff <= beat_in;
      end
   end

   assign beat_out         = out_ff;
   assign status.out_valid = out_valid_ff;
   assign status.skid_full = skid_valid_ff;

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HTTP request framer core.
// ----------------------------------------------------------------------------
// Feeds request streams (directed corner cases, then random well-formed
// requests mixed with noise) through the byte channel under varying idle and
// stall patterns. A local framing model predicts the tag on every byte. Each
// returned beat is checked against the oldest prediction. max_body_length is
// reprogrammed between traffic phases, including both of its extremes.
module tb;
   import hrf_pkg::*;

   typedef enum logic [2:0] {
      SCAN_NAME, SCAN_SPACES, SCAN_PLUS, SCAN_MINUS,
      SCAN_DIGITS_POS, SCAN_DIGITS_NEG, SCAN_SKIP, SCAN_BODY
   } scan_state_type;

   localparam int unsigned QUIET_LIMIT  = 5000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int          HOLD_PHASE   = 4;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          MAX_REPORTS  = 10;
   localparam logic [CSR_ADDR_WIDTH-1:0] MAX_LEN_ADDR = {REG_MAX_BODY_LENGTH, 2'b00};
   localparam logic [8*15-1:0] LEN_NAME = "Content-Length:";

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_in_body;
   logic       rsp_last;
   logic       rsp_length_error;

   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   http_request_framer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_in_body      (rsp_in_body),
      .rsp_last         (rsp_last),
      .rsp_length_error (rsp_length_error),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [7:0]   stream_bytes[$];
   hrf_beat_type expected_beats[$];

   int          run_phase = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;

   // framing model state
   logic [30:0]    max_len_cfg;
   logic [1:0]     term_prog;
   logic [3:0]     name_prog;
   scan_state_type scan;
   logic           len_found;
   logic [31:0]    len_value;
   logic [31:0]    body_left;
   logic           err_seen;

   function automatic void restart_request();
      term_prog = '0;
      name_prog = '0;
      scan      = SCAN_NAME;
      len_found = 1'b0;
      len_value = '0;
      body_left = '0;
      err_seen  = 1'b0;
   endfunction

   function automatic void add_digit(input logic [3:0] d, input logic negative);
      logic [63:0] v;
      v = {32'h0, len_value} * 64'd10 + {60'h0, d};
      if (v > 64'hFFFF_FFFF) begin
         err_seen = 1'b1;
         v = 64'hFFFF_FFFF;
      end
      if (negative && d != 4'd0)
         err_seen = 1'b1;
      len_value = v[31:0];
   endfunction

   function automatic void scan_header(input logic [7:0] b);
      logic       is_digit;
      logic [7:0] diff;
      logic       negative;
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      diff     = b - CHAR_ZERO;
      case (scan)
         SCAN_NAME: begin
            if (name_prog < NAME_LEN && b == LEN_NAME[8*(NAME_LAST - name_prog) +: 8]) begin
               name_prog = name_prog + 4'd1;
               if (name_prog == NAME_LEN) begin
                  len_found = 1'b1;
                  name_prog = '0;
                  scan      = SCAN_SPACES;
               end
            end else begin
               name_prog = (b == CHAR_UPPER_C) ? 4'd1 : 4'd0;
            end
         end
         SCAN_SPACES: begin
            if (b == CHAR_SPACE) begin
               scan = SCAN_SPACES;
            end else if (b == CHAR_PLUS) begin
               scan = SCAN_PLUS;
            end else if (b == CHAR_MINUS) begin
               scan = SCAN_MINUS;
            end else if (is_digit) begin
               len_value = '0;
               add_digit(diff[3:0], 1'b0);
               scan = SCAN_DIGITS_POS;
            end else begin
               err_seen = 1'b1;
               scan     = SCAN_SKIP;
            end
         end
         SCAN_PLUS, SCAN_MINUS: begin
            if (is_digit) begin
               negative  = (scan == SCAN_MINUS);
               len_value = '0;
               add_digit(diff[3:0], negative);
               scan = negative ? SCAN_DIGITS_NEG : SCAN_DIGITS_POS;
            end else begin
               err_seen = 1'b1;
               scan     = SCAN_SKIP;
            end
         end
         SCAN_DIGITS_POS, SCAN_DIGITS_NEG: begin
            if (is_digit)
               add_digit(diff[3:0], scan == SCAN_DIGITS_NEG);
            else
               scan = SCAN_SKIP;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic hrf_beat_type frame_byte(input logic [7:0] b);
      hrf_beat_type r;
      logic [31:0]  len;
      logic         term_hit;
      r          = '0;
      r.out_byte = b;
      if (scan == SCAN_BODY) begin
         r.in_body = 1'b1;
         if (body_left != 0)
            body_left = body_left - 32'd1;
         if (body_left == 0) begin
            r.last = 1'b1;
            restart_request();
         end
      end else begin
         scan_header(b);
         term_hit = 1'b0;
         // terminator is CR LF CR LF: even positions want CR, odd want LF
         if (b == (term_prog[0] ? CHAR_LF : CHAR_CR)) begin
            if (term_prog == 2'd3) begin
               term_prog = '0;
               term_hit  = 1'b1;
            end else begin
               term_prog = term_prog + 2'd1;
            end
         end else begin
            term_prog = (b == CHAR_CR) ? 2'd1 : 2'd0;
         end
         if (term_hit) begin
            len = '0;
            if (len_found) begin
               if (err_seen || len_value > {1'b0, max_len_cfg})
                  r.length_error = 1'b1;
               else
                  len = len_value;
            end
            if (len == 0) begin
               r.last = 1'b1;
               restart_request();
            end else begin
               term_prog = '0;
               name_prog = '0;
               body_left = len;
               scan      = SCAN_BODY;
            end
         end
      end
      return r;
   endfunction

   // sender: one beat per free slot, random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_beats.push_back(frame_byte(req_data_byte));
         if (!req_valid || !req_stall) begin
            if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid     <= 1'b1;
               req_data_byte <= stream_bytes.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks beats, random stalls, one long hold-off
   always @(posedge clock) begin : receiver
      hrf_beat_type want;
      hrf_beat_type got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_out_byte, rsp_in_body, rsp_last, rsp_length_error};
            if (expected_beats.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected beat: byte %h body %b last %b err %b",
                           got.out_byte, got.in_body, got.last, got.length_error);
            end else begin
               want = expected_beats.pop_front();
               if (got.out_byte !== want.out_byte || got.in_body !== want.in_body ||
                   got.last !== want.last || got.length_error !== want.length_error) begin
                  mismatches = mismatches + 1;
                  // fields in order: byte, body, last, err
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch at %0t: expected %h %b %b %b, got %h %b %b %b",
                              $realtime, want.out_byte, want.in_body, want.last,
                              want.length_error, got.out_byte, got.in_body, got.last,
                              got.length_error);
               end
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (run_phase == HOLD_PHASE && !hold_done) begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic program_max_len(input logic [31:0] word);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MAX_LEN_ADDR;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      max_len_cfg = word[30:0];
   endtask

   task automatic set_traffic(input int ph, input int unsigned s_pct, input int unsigned r_pct);
      @(posedge clock);
      run_phase     <= ph;
      send_idle_pct <= s_pct;
      recv_idle_pct <= r_pct;
      @(negedge clock);
   endtask

   task automatic drain();
      while (stream_bytes.size() != 0 || req_valid || expected_beats.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         stream_bytes.push_back(s[i]);
   endtask

   task automatic push_line(input string s);
      push_text(s);
      stream_bytes.push_back(CHAR_CR);
      stream_bytes.push_back(CHAR_LF);
   endtask

   task automatic push_random_line();
      int n;
      n = $urandom_range(1, 12);
      repeat (n) stream_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
      stream_bytes.push_back(CHAR_CR);
      stream_bytes.push_back(CHAR_LF);
   endtask

   task automatic push_body(input int n);
      repeat (n) stream_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // request line, a few filler lines around the given field lines, blank line
   task automatic push_header(input string field, input string extra);
      push_line("GET /index.html HTTP/1.1");
      repeat ($urandom_range(0, 2)) push_random_line();
      if (field.len() != 0)
         push_line(field);
      if (extra.len() != 0) begin
         push_random_line();
         push_line(extra);
      end
      repeat ($urandom_range(0, 2)) push_random_line();
      push_line("");
   endtask

   task automatic push_limit_edges();
      if (max_len_cfg <= 300) begin
         push_header($sformatf("Content-Length: %0d", max_len_cfg), "");
         push_body(int'(max_len_cfg));
      end
      push_header($sformatf("Content-Length: %0d", {1'b0, max_len_cfg} + 32'd1), "");
   endtask

   task automatic push_random_request();
      int              kind;
      int              body_len;
      int              top;
      longint unsigned v;
      string           pad;
      string           field;
      string           extra;
      string           digits;
      pad      = "";
      field    = "";
      extra    = "";
      digits   = "";
      body_len = 0;
      repeat ($urandom_range(0, 3)) pad = {pad, " "};
      top  = (max_len_cfg < 24) ? int'(max_len_cfg) : 24;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         // noise, then a terminator to pull the stream back into step
         repeat ($urandom_range(1, 16)) stream_bytes.push_back(8'($urandom_range(0, 255)));
         push_line("");
         push_line("");
         return;
      end else if (kind < 18) begin
         field = "";
      end else if (kind < 60) begin
         v = $urandom_range(0, top);
         if (max_len_cfg >= 300 && $urandom_range(0, 39) == 0)
            v = $urandom_range(100, 300);
         field = $sformatf("Content-Length:%s%s%0d", pad,
                           ($urandom_range(0, 3) == 0) ? "+" : "", v);
         body_len = int'(v);
      end else if (kind < 67) begin
         v = longint'(max_len_cfg) + 1 + ($urandom % (64'hFFFF_FFFF - max_len_cfg));
         field = $sformatf("Content-Length:%s%0d", pad, v);
      end else if (kind < 72) begin
         field = $sformatf("Content-Length:%s-%0d", pad, $urandom_range(1, 99999));
      end else if (kind < 75) begin
         field = $sformatf("Content-Length:%s-%s", pad, ($urandom_range(0, 1) == 0) ? "0" : "000");
      end else if (kind < 81) begin
         case ($urandom_range(0, 3))
            0:       field = {"Content-Length:", pad};
            1:       field = {"Content-Length:", pad, "+"};
            2:       field = {"Content-Length:", pad, "-x"};
            default: field = {"Content-Length:", pad, "abc"};
         endcase
      end else if (kind < 87) begin
         digits = $sformatf("%0d", $urandom_range(1, 9));
         repeat ($urandom_range(10, 14)) digits = $sformatf("%s%0d", digits, $urandom_range(0, 9));
         field = {"Content-Length:", pad, digits};
      end else if (kind < 93) begin
         v = $urandom_range(0, top);
         field = $sformatf("Content-Length:%s%0d%s", pad, v,
                           ($urandom_range(0, 1) == 0) ? "; q=1" : "xyz");
         body_len = int'(v);
      end else begin
         v = $urandom_range(0, top);
         field = $sformatf("Content-Length: %0d", v);
         extra = $sformatf("Content-Length: %0d", $urandom_range(0, 999));
         body_len = int'(v);
      end
      push_header(field, extra);
      push_body(body_len);
   endtask

   task automatic push_random_bytes(input int budget);
      while (stream_bytes.size() < budget)
         push_random_request();
   endtask

   initial begin
      restart_request();
      max_len_cfg = MAX_LEN_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed corner cases at the reset limit
      set_traffic(0, 18, 77);
      push_line("");
      push_line("");
      push_header("Content-Length: 3", "");
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'hFF);
      stream_bytes.push_back(CHAR_CR);
      push_header("Content-Length:+2", "");
      push_body(2);
      push_header("Content-Length:-0", "");
      push_header("Content-Length:-5", "");
      push_header("Content-Length:   ", "");
      push_header("Content-Length:+x", "");
      push_header("Content-Length: -", "");
      push_header("Content-Length: 4abc", "");
      push_line("");
      push_line("");
      push_header("Content-Length: 99999999999", "");
      push_header("Content-Length: 4294967295", "");
      push_header("Content-Length: 2147483648", "");
      push_header("Content-Length: 2", "Content-Length: 7");
      push_body(2);
      push_header("CContent-Length: 1", "");
      push_body(1);
      push_header("content-length: 5", "");
      push_header("Content-Length:007", "");
      push_body(7);
      stream_bytes.push_back(CHAR_CR);
      push_line("Host: a");
      push_line("");
      push_random_bytes(60);
      drain();

      program_max_len(32'h0000_0000);
      set_traffic(1, 18, 77);
      push_limit_edges();
      push_random_bytes(180);
      drain();

      program_max_len(32'h8000_0005);
      set_traffic(2, 77, 18);
      push_limit_edges();
      push_random_bytes(200);
      drain();

      program_max_len({1'($urandom_range(0, 1)), 31'($urandom_range(1, 40))});
      set_traffic(3, 77, 18);
      push_limit_edges();
      push_random_bytes(200);
      drain();

      // no idling; the receiver holds off for a long stretch here
      program_max_len(32'hFFFF_FFFF);
      set_traffic(HOLD_PHASE, 0, 0);
      push_limit_edges();
      push_random_bytes(250);
      drain();

      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
